// ===== hw/rtl/dmc_pkg.sv =====
package dmc_pkg;

    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_MAZE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAZE_HEIGHT = 1'd1;

    localparam logic [CFG_W-1:0] MAZE_WIDTH_RESET  = 7'd16;
    localparam logic [CFG_W-1:0] MAZE_HEIGHT_RESET = 7'd16;
    localparam logic [CFG_W-1:0] MAZE_SIZE_MIN     = 7'd2;

    localparam logic FUNC_MOVE  = 1'b0;
    localparam logic FUNC_BEGIN = 1'b1;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    typedef struct packed {
        logic       go;
        logic       begin_maze;
        logic [1:0] dir;
    } req_t;

    typedef struct packed {
        logic       valid;
        logic       done;
        logic [1:0] side;
    } res_t;

endpackage

// ===== hw/rtl/dmc_ram.sv =====
module dmc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/dmc_walk.sv =====
module dmc_walk #(
    parameter int MAX_WIDTH  = dmc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = dmc_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  dmc_pkg::req_t                                       req,
    output logic                                                req_ready,
    input  logic [$clog2(MAX_WIDTH):0]                          eff_w,
    input  logic [$clog2(MAX_HEIGHT):0]                         eff_h,
    input  logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT):0]       total,
    output dmc_pkg::res_t                                       res,
    output logic [$clog2(MAX_WIDTH)-1:0]                        res_x,
    output logic [$clog2(MAX_HEIGHT)-1:0]                       res_y,
    input  logic                                                res_ready
);

    localparam int XW          = $clog2(MAX_WIDTH);
    localparam int YW          = $clog2(MAX_HEIGHT);
    localparam int AW          = XW + YW;
    localparam int MAP_DEPTH   = 2 ** AW;
    localparam int STACK_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int SAW         = $clog2(STACK_DEPTH);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_PROBE  = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;
    localparam logic [2:0] ST_POP    = 3'd5;

    logic [2:0]    state_reg;
    logic [AW-1:0] clr_addr_reg;
    logic          origin_reg;
    logic [XW-1:0] cur_x_reg;
    logic [YW-1:0] cur_y_reg;
    logic [SAW:0]  depth_reg;
    logic [AW:0]   count_reg;
    logic          finished_reg;
    logic [1:0]    dir_reg;
    logic [1:0]    probe_reg;
    logic          rd_pend_reg;
    logic [1:0]    rd_dir_reg;
    logic [3:0]    free_reg;

    logic [XW:0]   x_ext;
    logic [YW:0]   y_ext;
    logic [3:0]    inb;
    logic [3:0]    free_comb;
    logic          stuck;
    logic          move_ok;
    logic          emit_fire;
    logic [AW:0]   count_inc;
    logic [AW-1:0] probe_nb;
    logic [AW-1:0] emit_nb;
    logic          pop_issue;

    logic          map_wr_en;
    logic [AW-1:0] map_wr_addr;
    logic [0:0]    map_wr_data;
    logic [0:0]    map_rd_data;
    logic          stk_wr_en;
    logic [1:0]    stk_rd_data;

    function automatic logic [AW-1:0] nb_addr(input logic [XW-1:0] x,
                                               input logic [YW-1:0] y,
                                               input logic [1:0]    d);
        logic [XW-1:0] nx;
        logic [YW-1:0] ny;
        nx = x;
        ny = y;
        case (d)
            dmc_pkg::DIR_UP:    ny = y - 1'b1;
            dmc_pkg::DIR_DOWN:  ny = y + 1'b1;
            dmc_pkg::DIR_LEFT:  nx = x - 1'b1;
            dmc_pkg::DIR_RIGHT: nx = x + 1'b1;
            default:            nx = x;
        endcase
        return {ny, nx};
    endfunction

    assign x_ext = {1'b0, cur_x_reg};
    assign y_ext = {1'b0, cur_y_reg};

    always_comb
    begin
        inb[dmc_pkg::DIR_UP]    = (cur_y_reg != '0) && (x_ext < eff_w)
                                  && ((y_ext - (YW+1)'(1)) < eff_h);
        inb[dmc_pkg::DIR_DOWN]  = (x_ext < eff_w) && ((y_ext + (YW+1)'(1)) < eff_h);
        inb[dmc_pkg::DIR_LEFT]  = (cur_x_reg != '0) && (y_ext < eff_h)
                                  && ((x_ext - (XW+1)'(1)) < eff_w);
        inb[dmc_pkg::DIR_RIGHT] = (y_ext < eff_h) && ((x_ext + (XW+1)'(1)) < eff_w);
    end

    always_comb
    begin
        free_comb = free_reg;
        if (rd_pend_reg)
        begin
            free_comb[rd_dir_reg] = inb[rd_dir_reg] & ~map_rd_data[0];
        end
    end

    assign stuck     = (free_comb == 4'b0000);
    assign move_ok   = free_comb[dir_reg];
    assign probe_nb  = nb_addr(cur_x_reg, cur_y_reg, probe_reg);
    assign emit_nb   = nb_addr(cur_x_reg, cur_y_reg, dir_reg);
    assign count_inc = count_reg + (AW+1)'(1);
    assign pop_issue = (state_reg == ST_DECIDE) && stuck && (depth_reg != '0);

    assign req_ready = (state_reg == ST_IDLE);

    assign res.valid = ((state_reg == ST_DECIDE) && move_ok) || (state_reg == ST_EMIT);
    assign res.done  = (count_inc >= total);
    assign res.side  = dir_reg;
    assign res_x     = cur_x_reg;
    assign res_y     = cur_y_reg;
    assign emit_fire = res.valid && res_ready;

    assign map_wr_en   = (state_reg == ST_CLEAR) || emit_fire;
    assign map_wr_addr = (state_reg == ST_CLEAR) ? clr_addr_reg : emit_nb;
    assign map_wr_data = (state_reg == ST_CLEAR) ? (origin_reg && (clr_addr_reg == '0))
                                                 : 1'b1;
    assign stk_wr_en   = emit_fire && (depth_reg < STACK_DEPTH);

    dmc_ram #(
        .WIDTH (1),
        .DEPTH (MAP_DEPTH)
    ) u_visited (
        .clk     (clk),
        .wr_en   (map_wr_en),
        .wr_addr (map_wr_addr),
        .wr_data (map_wr_data),
        .rd_en   (state_reg == ST_PROBE),
        .rd_addr (probe_nb),
        .rd_data (map_rd_data)
    );

    dmc_ram #(
        .WIDTH (2),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .wr_en   (stk_wr_en),
        .wr_addr (depth_reg[SAW-1:0]),
        .wr_data (dir_reg),
        .rd_en   (pop_issue),
        .rd_addr (SAW'(depth_reg - (SAW+1)'(1))),
        .rd_data (stk_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            origin_reg   <= 1'b0;
            cur_x_reg    <= '0;
            cur_y_reg    <= '0;
            depth_reg    <= '0;
            count_reg    <= '0;
            finished_reg <= 1'b0;
            dir_reg      <= dmc_pkg::DIR_UP;
            probe_reg    <= dmc_pkg::DIR_UP;
            rd_pend_reg  <= 1'b0;
            rd_dir_reg   <= dmc_pkg::DIR_UP;
            free_reg     <= 4'b0000;
        end
        else
        begin
            rd_pend_reg <= (state_reg == ST_PROBE);
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == '1)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (req.go)
                    begin
                        if (req.begin_maze)
                        begin
                            cur_x_reg    <= '0;
                            cur_y_reg    <= '0;
                            depth_reg    <= '0;
                            count_reg    <= (AW+1)'(1);
                            finished_reg <= 1'b0;
                            origin_reg   <= 1'b1;
                            clr_addr_reg <= '0;
                            state_reg    <= ST_CLEAR;
                        end
                        else
                        begin
                            dir_reg <= req.dir;
                            if (!finished_reg && (count_reg < total))
                            begin
                                probe_reg <= dmc_pkg::DIR_UP;
                                free_reg  <= 4'b0000;
                                state_reg <= ST_PROBE;
                            end
                        end
                    end
                end
                ST_PROBE:
                begin
                    rd_dir_reg  <= probe_reg;
                    probe_reg   <= probe_reg + 1'b1;
                    free_reg    <= free_comb;
                    if (probe_reg == dmc_pkg::DIR_RIGHT)
                    begin
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE:
                begin
                    free_reg <= free_comb;
                    if (stuck)
                    begin
                        if (depth_reg != '0)
                        begin
                            depth_reg <= depth_reg - (SAW+1)'(1);
                            state_reg <= ST_POP;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                    else if (move_ok && !res_ready)
                    begin
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_EMIT:
                begin
                    if (res_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_POP:
                begin
                    case (stk_rd_data)
                        dmc_pkg::DIR_UP:
                        begin
                            if ((int'(cur_y_reg) + 1) < MAX_HEIGHT)
                            begin
                                cur_y_reg <= cur_y_reg + 1'b1;
                            end
                        end
                        dmc_pkg::DIR_DOWN:
                        begin
                            if (cur_y_reg != '0)
                            begin
                                cur_y_reg <= cur_y_reg - 1'b1;
                            end
                        end
                        dmc_pkg::DIR_LEFT:
                        begin
                            if ((int'(cur_x_reg) + 1) < MAX_WIDTH)
                            begin
                                cur_x_reg <= cur_x_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                            if (cur_x_reg != '0)
                            begin
                                cur_x_reg <= cur_x_reg - 1'b1;
                            end
                        end
                    endcase
                    probe_reg <= dmc_pkg::DIR_UP;
                    free_reg  <= 4'b0000;
                    state_reg <= ST_PROBE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (emit_fire)
            begin
                cur_y_reg    <= emit_nb[AW-1:XW];
                cur_x_reg    <= emit_nb[XW-1:0];
                count_reg    <= count_inc;
                finished_reg <= res.done;
                if (depth_reg < STACK_DEPTH)
                begin
                    depth_reg <= depth_reg + (SAW+1)'(1);
                end
            end
        end
    end

    a_emit_counts: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |=> count_reg == $past(count_inc))
        else $error("visited count did not advance on a wall removal");

    a_pop_depth: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_POP |-> (depth_reg + (SAW+1)'(1)) == $past(depth_reg))
        else $error("step back without a stack entry");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= STACK_DEPTH)
        else $error("direction stack overflow");

    a_begin_clears: assert property (@(posedge clk) disable iff (!rst_n)
        req.go && req_ready && req.begin_maze
        |=> state_reg == ST_CLEAR && count_reg == (AW+1)'(1) && depth_reg == '0)
        else $error("begin did not restart the walk");

endmodule

// ===== hw/rtl/dfs_maze_carver.sv =====
// Maze carver: a randomised depth-first walk over a grid of up to MAX_WIDTH by MAX_HEIGHT cells.
// Input words (s_*) carry a direction in s_tdata and the function in s_tuser: a begin word
// restarts the maze at cell (0,0), a move word tries the direction it carries. Each move word gives
// at most one output word (m_*), the wall removal towards the newly visited cell; m_tlast marks
// the removal that visits the last cell. Begin words and refused moves give no output.
// The grid size registers are written over the cfg_* channel, which is always ready.
// A move word passes through four probe steps, which read the four neighbour bits of the
// visited map, and a decision step, which writes back and loads the output register. The
// input is ready only at idle, so no new word is taken before the last one is done.
// Every step back along the direction stack adds a pop step that moves back by the popped
// direction, then the four neighbour reads and a further decision. The visited map has one read port.
// A begin word, and reset, start a clearing pass over every entry of the visited map,
// 2**(clog2(MAX_WIDTH)+clog2(MAX_HEIGHT)) of them (4096 by default); no input word is taken
// during it. After reset the size registers read 16 by 16.
// The output word sits in a register. While the receiver stalls the next input word is still
// taken, and the walk holds in its emit state until the waiting word has been taken.
module dfs_maze_carver #(
    parameter int MAX_WIDTH  = dmc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = dmc_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,  // move[1:0]
    input  logic [0:0]                    s_tuser,  // func[0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [((($clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT) + 2) + 7) / 8) * 8 - 1:0]
                                          m_tdata,  // wall_x, wall_y, wall_side
    output logic                          m_tlast,  // maze_done
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [dmc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dmc_pkg::CFG_W-1:0]     cfg_data
);

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int AW  = XW + YW;
    localparam int PW  = AW + 2;
    localparam int TDW = (((XW + YW + 2) + 7) / 8) * 8;

    logic [dmc_pkg::CFG_W-1:0] maze_width_reg;
    logic [dmc_pkg::CFG_W-1:0] maze_height_reg;
    logic [XW:0]               eff_w;
    logic [YW:0]               eff_h;
    logic [PW-1:0]             area;
    logic [AW:0]               total;

    dmc_pkg::req_t             req;
    logic                      req_ready;
    dmc_pkg::res_t             res;
    logic [XW-1:0]             res_x;
    logic [YW-1:0]             res_y;
    logic                      res_ready;

    logic                      out_valid_reg;
    logic [XW-1:0]             out_x_reg;
    logic [YW-1:0]             out_y_reg;
    logic [1:0]                out_side_reg;
    logic                      out_done_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            maze_width_reg  <= dmc_pkg::MAZE_WIDTH_RESET;
            maze_height_reg <= dmc_pkg::MAZE_HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                dmc_pkg::REG_MAZE_WIDTH:  maze_width_reg  <= cfg_data;
                dmc_pkg::REG_MAZE_HEIGHT: maze_height_reg <= cfg_data;
                default:                  maze_width_reg  <= maze_width_reg;
            endcase
        end
    end

    always_comb
    begin
        if (maze_width_reg < dmc_pkg::MAZE_SIZE_MIN)
        begin
            eff_w = (XW+1)'(dmc_pkg::MAZE_SIZE_MIN);
        end
        else if (int'(maze_width_reg) > MAX_WIDTH)
        begin
            eff_w = (XW+1)'(MAX_WIDTH);
        end
        else
        begin
            eff_w = (XW+1)'(maze_width_reg);
        end

        if (maze_height_reg < dmc_pkg::MAZE_SIZE_MIN)
        begin
            eff_h = (YW+1)'(dmc_pkg::MAZE_SIZE_MIN);
        end
        else if (int'(maze_height_reg) > MAX_HEIGHT)
        begin
            eff_h = (YW+1)'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = (YW+1)'(maze_height_reg);
        end
    end

    assign area  = PW'(eff_w) * PW'(eff_h);
    assign total = area[AW:0];

    assign req.go         = s_tvalid;
    assign req.begin_maze = (s_tuser[0] == dmc_pkg::FUNC_BEGIN);
    assign req.dir        = s_tdata[1:0];
    assign s_tready       = req_ready;

    assign res_ready = !out_valid_reg || m_tready;

    dmc_walk #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .req_ready (req_ready),
        .eff_w     (eff_w),
        .eff_h     (eff_h),
        .total     (total),
        .res       (res),
        .res_x     (res_x),
        .res_y     (res_y),
        .res_ready (res_ready)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_x_reg     <= '0;
            out_y_reg     <= '0;
            out_side_reg  <= dmc_pkg::DIR_UP;
            out_done_reg  <= 1'b0;
        end
        else if (res.valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
            out_x_reg     <= res_x;
            out_y_reg     <= res_y;
            out_side_reg  <= res.side;
            out_done_reg  <= res.done;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDW'({out_side_reg, out_y_reg, out_x_reg});
    assign m_tlast  = out_done_reg;

endmodule

// ===== tb/sv/dfs_maze_carver_tb.sv =====
`timescale 1ns / 100ps

module dfs_maze_carver_tb;

    localparam int MAXW           = dmc_pkg::DEF_MAX_WIDTH;
    localparam int MAXH           = dmc_pkg::DEF_MAX_HEIGHT;
    localparam int TRAIL_DEPTH    = MAXW * MAXH;
    localparam int CLEAR_CYCLES   = MAXW * MAXH + 16;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int PRINT_LIMIT    = 50;

    typedef struct packed {
        logic [5:0] x;
        logic [5:0] y;
        logic [1:0] side;
        logic       done;
    } wall_t;

    typedef struct {
        logic       fn;
        logic [1:0] mv;
        bit         fixed;
        bit         has_wall;
        wall_t      wall;
    } stim_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [dmc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [dmc_pkg::CFG_W-1:0]     cfg_data;

    logic [6:0]  cols_reg;
    logic [6:0]  rows_reg;
    bit          visited [MAXH][MAXW];
    logic [1:0]  trail [TRAIL_DEPTH];
    int          trail_len;
    int          pos_x;
    int          pos_y;
    int          cells_seen;
    bit          carved_all;

    wall_t       walls_due [$];
    int          errors;
    int          words_in;
    int          settle_cycles;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_off;
    int          idle_cycles;

    // Directed words at the reset size of 16 by 16, starting before any begin word.
    stim_t open_rows [9] = '{
        '{dmc_pkg::FUNC_MOVE,  dmc_pkg::DIR_UP,    1'b1, 1'b0, '0},
        '{dmc_pkg::FUNC_MOVE,  dmc_pkg::DIR_LEFT,  1'b1, 1'b0, '0},
        '{dmc_pkg::FUNC_MOVE,  dmc_pkg::DIR_RIGHT, 1'b1, 1'b1,
          {6'd0, 6'd0, dmc_pkg::DIR_RIGHT, 1'b0}},
        '{dmc_pkg::FUNC_MOVE,  dmc_pkg::DIR_LEFT,  1'b1, 1'b1,
          {6'd1, 6'd0, dmc_pkg::DIR_LEFT, 1'b0}},
        '{dmc_pkg::FUNC_BEGIN, dmc_pkg::DIR_RIGHT, 1'b1, 1'b0, '0},
        '{dmc_pkg::FUNC_MOVE,  dmc_pkg::DIR_RIGHT, 1'b1, 1'b1,
          {6'd0, 6'd0, dmc_pkg::DIR_RIGHT, 1'b0}},
        '{dmc_pkg::FUNC_MOVE,  dmc_pkg::DIR_LEFT,  1'b1, 1'b0, '0},
        '{dmc_pkg::FUNC_MOVE,  dmc_pkg::DIR_DOWN,  1'b1, 1'b1,
          {6'd1, 6'd0, dmc_pkg::DIR_DOWN, 1'b0}},
        '{dmc_pkg::FUNC_MOVE,  dmc_pkg::DIR_UP,    1'b1, 1'b0, '0}
    };

    // Two complete mazes on the smallest grid, with a move after completion.
    stim_t tiny_rows [9] = '{
        '{dmc_pkg::FUNC_BEGIN, dmc_pkg::DIR_UP,    1'b1, 1'b0, '0},
        '{dmc_pkg::FUNC_MOVE,  dmc_pkg::DIR_RIGHT, 1'b1, 1'b1,
          {6'd0, 6'd0, dmc_pkg::DIR_RIGHT, 1'b0}},
        '{dmc_pkg::FUNC_MOVE,  dmc_pkg::DIR_DOWN,  1'b1, 1'b1,
          {6'd1, 6'd0, dmc_pkg::DIR_DOWN, 1'b0}},
        '{dmc_pkg::FUNC_MOVE,  dmc_pkg::DIR_LEFT,  1'b1, 1'b1,
          {6'd1, 6'd1, dmc_pkg::DIR_LEFT, 1'b1}},
        '{dmc_pkg::FUNC_MOVE,  dmc_pkg::DIR_UP,    1'b1, 1'b0, '0},
        '{dmc_pkg::FUNC_BEGIN, dmc_pkg::DIR_LEFT,  1'b1, 1'b0, '0},
        '{dmc_pkg::FUNC_MOVE,  dmc_pkg::DIR_DOWN,  1'b1, 1'b1,
          {6'd0, 6'd0, dmc_pkg::DIR_DOWN, 1'b0}},
        '{dmc_pkg::FUNC_MOVE,  dmc_pkg::DIR_RIGHT, 1'b1, 1'b1,
          {6'd0, 6'd1, dmc_pkg::DIR_RIGHT, 1'b0}},
        '{dmc_pkg::FUNC_MOVE,  dmc_pkg::DIR_UP,    1'b1, 1'b1,
          {6'd1, 6'd1, dmc_pkg::DIR_UP, 1'b1}}
    };

    dfs_maze_carver uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int span_x();
        if (cols_reg < 2) return 2;
        if (cols_reg > MAXW) return MAXW;
        return int'(cols_reg);
    endfunction

    function automatic int span_y();
        if (rows_reg < 2) return 2;
        if (rows_reg > MAXH) return MAXH;
        return int'(rows_reg);
    endfunction

    function automatic bit next_cell(input int x, input int y, input logic [1:0] d,
                                     output int nx, output int ny);
        nx = x;
        ny = y;
        case (d)
            dmc_pkg::DIR_UP:
            begin
                if (y == 0) return 1'b0;
                ny = y - 1;
            end
            dmc_pkg::DIR_DOWN:
                ny = y + 1;
            dmc_pkg::DIR_LEFT:
            begin
                if (x == 0) return 1'b0;
                nx = x - 1;
            end
            default:
                nx = x + 1;
        endcase
        return nx < span_x() && ny < span_y();
    endfunction

    function automatic bit boxed_in();
        int nx;
        int ny;
        for (int d = 0; d < 4; d++)
        begin
            if (next_cell(pos_x, pos_y, 2'(d), nx, ny) && !visited[ny][nx]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Advances the walk by one word and gives the wall it knocks down, if any.
    function automatic bit carve_step(input logic fn, input logic [1:0] mv, output wall_t w);
        int total;
        int nx;
        int ny;
        int steps;
        steps = 0;
        w = '0;
        if (fn == dmc_pkg::FUNC_BEGIN)
        begin
            foreach (visited[i, j]) visited[i][j] = 1'b0;
            visited[0][0] = 1'b1;
            pos_x = 0;
            pos_y = 0;
            trail_len = 0;
            cells_seen = 1;
            carved_all = 1'b0;
            settle_cycles += CLEAR_CYCLES;
            return 1'b0;
        end
        total = span_x() * span_y();
        if (carved_all || cells_seen >= total)
        begin
            settle_cycles += 8;
            return 1'b0;
        end
        while (boxed_in() && trail_len > 0)
        begin
            trail_len--;
            case (trail[trail_len])
                dmc_pkg::DIR_UP:   if (pos_y + 1 < MAXH) pos_y++;
                dmc_pkg::DIR_DOWN: if (pos_y > 0) pos_y--;
                dmc_pkg::DIR_LEFT: if (pos_x + 1 < MAXW) pos_x++;
                default:           if (pos_x > 0) pos_x--;
            endcase
            steps++;
        end
        if (!next_cell(pos_x, pos_y, mv, nx, ny) || visited[ny][nx])
        begin
            settle_cycles += 8 + 8 * steps;
            return 1'b0;
        end
        w.x = 6'(pos_x);
        w.y = 6'(pos_y);
        w.side = mv;
        if (trail_len < TRAIL_DEPTH)
        begin
            trail[trail_len] = mv;
            trail_len++;
        end
        pos_x = nx;
        pos_y = ny;
        visited[ny][nx] = 1'b1;
        cells_seen++;
        if (cells_seen >= total) carved_all = 1'b1;
        w.done = carved_all;
        settle_cycles = 0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (errors < PRINT_LIMIT)
            $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    task automatic send_word(input stim_t st);
        wall_t w;
        bit got;
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser = st.fn;
        s_tdata = {6'd0, st.mv};
        do @(posedge clk); while (!s_tready);
        got = carve_step(st.fn, st.mv, w);
        words_in++;
        if (st.fixed)
        begin
            got = st.has_wall;
            w = st.wall;
        end
        if (got) walls_due = {walls_due, w};
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [dmc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dmc_pkg::CFG_W-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == dmc_pkg::REG_MAZE_WIDTH) cols_reg = val;
        else rows_reg = val;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // The block may still be walking back or clearing after its last output word.
    task automatic quiesce();
        s_tvalid = 1'b0;
        wait (walls_due.size() == 0);
        repeat (settle_cycles + 20) @(negedge clk);
        settle_cycles = 0;
    endtask

    task automatic hold_off_stretch();
        int base;
        base = words_in;
        wait (words_in >= base + 12);
        hold_off = 1'b1;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
    endtask

    task automatic play_mazes(input int count, input bit keep);
        int left;
        int run;
        int cells;
        stim_t st;
        left = count;
        cells = span_x() * span_y();
        st.fixed = 1'b0;
        st.has_wall = 1'b0;
        st.wall = '0;
        while (left > 0)
        begin
            if (!keep)
            begin
                st.fn = dmc_pkg::FUNC_BEGIN;
                st.mv = 2'($urandom_range(3, 0));
                send_word(st);
                left--;
            end
            keep = 1'b0;
            run = $urandom_range(6 * cells, 3 * cells);
            if (run > 150) run = 150;
            while (run > 0 && left > 0)
            begin
                st.fn = ($urandom_range(99, 0) < 4) ? dmc_pkg::FUNC_BEGIN : dmc_pkg::FUNC_MOVE;
                st.mv = 2'($urandom_range(3, 0));
                send_word(st);
                left--;
                run--;
            end
        end
    endtask

    task automatic run_phase(input logic [6:0] w, input logic [6:0] h, input int snd,
                             input int rcv, input int count, input bit keep, input bit press);
        quiesce();
        write_reg(dmc_pkg::REG_MAZE_WIDTH, w);
        write_reg(dmc_pkg::REG_MAZE_HEIGHT, h);
        send_idle_pct = snd;
        recv_stall_pct = rcv;
        if (press)
        begin
            fork
                hold_off_stretch();
                play_mazes(count, keep);
            join
        end
        else
        begin
            play_mazes(count, keep);
        end
    endtask

    always @(negedge clk)
    begin
        m_tready = !hold_off && ($urandom_range(99, 0) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        wall_t got;
        wall_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[5:0], m_tdata[11:6], m_tdata[13:12], m_tlast};
            if (walls_due.size() == 0)
            begin
                report_mismatch("unexpected word, wall_x", got.x, 0);
            end
            else
            begin
                want = walls_due.pop_front();
                if (got.x !== want.x) report_mismatch("wall_x", got.x, want.x);
                if (got.y !== want.y) report_mismatch("wall_y", got.y, want.y);
                if (got.side !== want.side) report_mismatch("wall_side", got.side, want.side);
                if (got.done !== want.done) report_mismatch("maze_done", got.done, want.done);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("dfs_maze_carver test failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = dmc_pkg::FUNC_MOVE;
        cfg_valid = 1'b0;
        cfg_index = dmc_pkg::REG_MAZE_WIDTH;
        cfg_data = '0;
        cols_reg = dmc_pkg::MAZE_WIDTH_RESET;
        rows_reg = dmc_pkg::MAZE_HEIGHT_RESET;
        foreach (visited[i, j]) visited[i][j] = 1'b0;
        trail_len = 0;
        pos_x = 0;
        pos_y = 0;
        cells_seen = 0;
        carved_all = 1'b0;
        errors = 0;
        words_in = 0;
        settle_cycles = CLEAR_CYCLES;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1'b0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (open_rows[i]) send_word(open_rows[i]);
        quiesce();
        write_reg(dmc_pkg::REG_MAZE_WIDTH, dmc_pkg::MAZE_SIZE_MIN);
        write_reg(dmc_pkg::REG_MAZE_HEIGHT, dmc_pkg::MAZE_SIZE_MIN);
        foreach (tiny_rows[i]) send_word(tiny_rows[i]);

        run_phase(7'd3,   7'd2,   0,  0,  130, 1'b0, 1'b0);
        run_phase(7'd5,   7'd4,   47, 0,  120, 1'b0, 1'b0);
        run_phase(7'd2,   7'd7,   0,  47, 120, 1'b0, 1'b0);
        run_phase(7'd64,  7'd2,   16, 16, 110, 1'b0, 1'b0);
        run_phase(7'd4,   7'd4,   0,  0,  110, 1'b0, 1'b1);
        run_phase(7'd0,   7'd127, 47, 0,  110, 1'b0, 1'b0);
        run_phase(7'd1,   7'd3,   0,  47, 100, 1'b0, 1'b0);
        run_phase(7'd64,  7'd64,  16, 16, 80,  1'b0, 1'b0);
        run_phase(7'd40,  7'd30,  0,  0,  130, 1'b1, 1'b0);
        quiesce();

        if (errors == 0)
        begin
            $display("dfs_maze_carver test passed");
        end
        else
        begin
            $display("dfs_maze_carver test failed");
        end
        $finish;
    end

endmodule
